/* hdl/oaht_pkg.sv */
package oaht_pkg;

   // Table geometry and field widths
   localparam int CAPACITY_DEFAULT = 64;
   localparam int MODE_W           = 2;
   localparam int KEY_W            = 32;
   localparam int HASH_W           = 32;
   localparam int VALUE_W          = 64;
   localparam int LIMIT_W          = 6;
   localparam int MARK_W           = 2;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // Slot word layout: mark in the low bits, then key, then value
   localparam int WORD_W     = MARK_W + KEY_W + VALUE_W;
   localparam int KEY_LSB    = MARK_W;
   localparam int VALUE_LSB  = MARK_W + KEY_W;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = LIMIT_W'(48);

   // Register index taken from the word address
   localparam logic REG_LOAD_LIMIT = 1'b0;

   // Slot marks
   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   // Operations
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_RESULT
   } state_type;

endpackage

/* hdl/oaht_ram.sv */
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/open_addressing_hash_table.sv */
// Open-addressing hash table, linear probing with tombstones.
//
// Request channel (req_*): tdata carries key_id, key_hash and write_value,
// tuser carries the operation (get, set, remove, anything else is a no-op).
// Response channel (rsp_*): tdata carries hit and read_value, tuser carries
// the reject status of a set. Exactly one response per request.
// CSR port: APB-style, one register (load_limit) at byte address 0.
//
// Timing: one slot is examined per cycle through a single slot memory with
// a registered read port. A request probes 1 to CAPACITY slots before its
// response is built; a get or remove on an empty table or a no-op skips
// the probe. One request is in flight at a time; req_tready drops from
// acceptance until the response is loaded into the output register, so a
// new request is taken only once the last one is through.
//
// Reset: a clearing pass writes every slot empty, one slot a cycle, so the
// block takes no request until the clearing pass has finished; CSR writes are
// taken throughout. If the receiver stalls, the response is held in the
// output register and the next request may still be accepted and probed.
module open_addressing_hash_table #(
   parameter int CAPACITY = oaht_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = key_id[31:0], key_hash[63:32], write_value[127:64]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [127:0]                        req_tdata,
   // tuser = mode[1:0]
   input  logic [oaht_pkg::MODE_W-1:0]         req_tuser,
   // response: tdata = hit[0], read_value[64:1], zero[71:65]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [71:0]                         rsp_tdata,
   // tuser = status[0]
   output logic                                rsp_tuser,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [oaht_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [oaht_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [oaht_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import oaht_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
   localparam logic [IDX_W-1:0] LAST_PROBE = IDX_W'(CAPACITY - 1);

   // request fields
   logic [KEY_W-1:0]   req_key_id;
   logic [HASH_W-1:0]  req_key_hash;
   logic [VALUE_W-1:0] req_write_value;

   assign req_key_id      = req_tdata[31:0];
   assign req_key_hash    = req_tdata[63:32];
   assign req_write_value = req_tdata[127:64];

   // control state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // request in flight
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   id_ff, id_in;
   logic [VALUE_W-1:0] wval_ff, wval_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   tomb_ff, tomb_in;
   logic               tomb_vld_ff, tomb_vld_in;

   // result being built, and the output register
   logic               hit_ff, hit_in;
   logic [VALUE_W-1:0] rval_ff, rval_in;
   logic               status_ff, status_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0] rsp_rval_ff, rsp_rval_in;
   logic               rsp_status_ff, rsp_status_in;

   // slot memory port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [WORD_W-1:0]  rd_data;

   // decoded slot under examination
   logic [MARK_W-1:0]  slot_mark;
   logic [KEY_W-1:0]   slot_key;
   logic [VALUE_W-1:0] slot_value;
   logic               is_empty, is_match, is_tomb, probe_done;
   logic               found, have_slot, slot_empty;
   logic [IDX_W-1:0]   slot_idx;
   logic               over_limit;
   logic               csr_write;

   oaht_ram #(
      .WIDTH(WORD_W),
      .DEPTH(CAPACITY)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign slot_mark  = rd_data[MARK_W-1:0];
   assign slot_key   = rd_data[KEY_LSB +: KEY_W];
   assign slot_value = rd_data[VALUE_LSB +: VALUE_W];

   // the one compare unit shared by every probe step
   assign is_empty   = (slot_mark == MARK_EMPTY);
   assign is_match   = (slot_mark == MARK_LIVE) && (slot_key == id_ff);
   assign is_tomb    = (slot_mark == MARK_TOMB);
   assign probe_done = is_empty || is_match || (n_ff == LAST_PROBE);

   // where a walk that ends here lands
   always_comb begin
      found      = 1'b0;
      have_slot  = 1'b0;
      slot_empty = 1'b0;
      slot_idx   = idx_ff;
      if (is_match) begin
         found     = 1'b1;
         have_slot = 1'b1;
      end else if (is_empty) begin
         have_slot  = 1'b1;
         slot_empty = !tomb_vld_ff;
         if (tomb_vld_ff) begin
            slot_idx = tomb_ff;
         end
      end else if (tomb_vld_ff) begin
         // whole table walked: fall back on the first tombstone
         have_slot = 1'b1;
         slot_idx  = tomb_ff;
      end else if (is_tomb) begin
         have_slot = 1'b1;
      end
   end

   // a fresh slot would push the count past the limit
   assign over_limit = (CMP_W'(used_ff) + CMP_W'(1)) > CMP_W'(limit_ff);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      used_in      = used_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      wval_in      = wval_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      tomb_in      = tomb_ff;
      tomb_vld_in  = tomb_vld_ff;
      hit_in       = hit_ff;
      rval_in      = rval_ff;
      status_in    = status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_rval_in   = rsp_rval_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {wval_ff, id_ff, MARK_LIVE};
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep every slot to empty
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{VALUE_W{1'b0}}, {KEY_W{1'b0}}, MARK_EMPTY};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_PROBE) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in     = req_tuser;
               id_in       = req_key_id;
               wval_in     = req_write_value;
               idx_in      = req_key_hash[IDX_W-1:0];
               n_in        = '0;
               tomb_vld_in = 1'b0;
               hit_in      = 1'b0;
               rval_in     = '0;
               status_in   = 1'b0;
               if ((req_tuser == MODE_NOP) ||
                   ((req_tuser != MODE_SET) && (used_ff == '0))) begin
                  // nothing to look up: answer a plain miss
                  state_in = ST_RESULT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_key_hash[IDX_W-1:0];
                  state_in = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            if (!probe_done) begin
               // remember the first tombstone, advance to the next slot
               if (is_tomb && !tomb_vld_ff) begin
                  tomb_in     = idx_ff;
                  tomb_vld_in = 1'b1;
               end
               idx_in  = idx_ff + 1'b1;
               n_in    = n_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
            end else begin
               state_in = ST_RESULT;
               case (mode_ff)
                  MODE_GET: begin
                     hit_in  = found;
                     rval_in = found ? slot_value : '0;
                  end
                  MODE_SET: begin
                     if (!have_slot) begin
                        status_in = 1'b1;
                     end else if (found) begin
                        // overwrite the value of an existing key
                        wr_en   = 1'b1;
                        wr_addr = slot_idx;
                     end else if (slot_empty && over_limit) begin
                        status_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_idx;
                        hit_in  = 1'b1;
                        if (slot_empty) begin
                           used_in = used_ff + 1'b1;
                        end
                     end
                  end
                  MODE_REMOVE: begin
                     if (found) begin
                        wr_en   = 1'b1;
                        wr_addr = slot_idx;
                        wr_data = {wval_ff, id_ff, MARK_TOMB};
                        hit_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_RESULT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_ff;
               rsp_rval_in   = rval_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      wval_ff       <= wval_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      tomb_ff       <= tomb_in;
      tomb_vld_ff   <= tomb_vld_in;
      hit_ff        <= hit_in;
      rval_ff       <= rval_in;
      status_ff     <= status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_rval_ff   <= rsp_rval_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_rval_ff, rsp_hit_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------------
   // CSR port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_LOAD_LIMIT)) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_LOAD_LIMIT) begin
         csr_prdata = CSR_DATA_W'(limit_ff);
      end
   end

endmodule
